// ===== hw/rtl/tntu_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle normal and tangent unit: shared types and constants
// Word formats, queue entry, unit request and result groups, state types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tntu_pkg;

  localparam int POS_WIDTH = 24;
  localparam int TEX_WIDTH = 20;
  localparam int OUT_WIDTH = 16;

  localparam int PD_WIDTH  = POS_WIDTH + 1;
  localparam int TD_WIDTH  = TEX_WIDTH + 1;
  localparam int MUL_WIDTH = (PD_WIDTH > TD_WIDTH) ? PD_WIDTH : TD_WIDTH;
  localparam int ACC_WIDTH = 2 * MUL_WIDTH + 1;
  localparam int SM_WIDTH  = 30;
  localparam int JUS_WIDTH = (ACC_WIDTH > SM_WIDTH) ? ACC_WIDTH : SM_WIDTH;
  localparam int SUM_WIDTH = 64;
  localparam int ROOT_WIDTH = 32;
  localparam int REM_WIDTH = 36;
  localparam int QB_WIDTH  = OUT_WIDTH + 1;
  localparam int NUM_WIDTH = SM_WIDTH + OUT_WIDTH;
  localparam int DIV_WIDTH = ROOT_WIDTH + OUT_WIDTH;
  localparam int BC_WIDTH  = $clog2(QB_WIDTH);

  localparam logic [1:0] LAST_CORNER = 2'd2;
  localparam logic [3:0] NUM_PROD    = 4'd14;
  localparam logic [2:0] DET_SLOT    = 3'd3;

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [POS_WIDTH-1:0] pos_z;
    logic signed [TEX_WIDTH-1:0] tex_u;
    logic signed [TEX_WIDTH-1:0] tex_v;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] normal_x;
    logic signed [OUT_WIDTH-1:0] normal_y;
    logic signed [OUT_WIDTH-1:0] normal_z;
    logic signed [OUT_WIDTH-1:0] tangent_x;
    logic signed [OUT_WIDTH-1:0] tangent_y;
    logic signed [OUT_WIDTH-1:0] tangent_z;
    logic                        normal_degenerate;
    logic                        tangent_degenerate;
  } out_word_t;

  typedef struct packed {
    logic signed [PD_WIDTH-1:0] e1_x;
    logic signed [PD_WIDTH-1:0] e1_y;
    logic signed [PD_WIDTH-1:0] e1_z;
    logic signed [PD_WIDTH-1:0] e2_x;
    logic signed [PD_WIDTH-1:0] e2_y;
    logic signed [PD_WIDTH-1:0] e2_z;
    logic signed [TD_WIDTH-1:0] du1;
    logic signed [TD_WIDTH-1:0] du2;
    logic signed [TD_WIDTH-1:0] dv1;
    logic signed [TD_WIDTH-1:0] dv2;
  } job_t;

  typedef struct packed {
    logic                        start;
    logic                        flip;
    logic signed [ACC_WIDTH-1:0] v0;
    logic signed [ACC_WIDTH-1:0] v1;
    logic signed [ACC_WIDTH-1:0] v2;
  } unit_req_t;

  typedef struct packed {
    logic                        done;
    logic                        degen;
    logic signed [OUT_WIDTH-1:0] c0;
    logic signed [OUT_WIDTH-1:0] c1;
    logic signed [OUT_WIDTH-1:0] c2;
  } unit_res_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_NSTART, B_NWAIT, B_TSTART, B_TWAIT, B_FINISH
  } back_state_t;

  typedef enum logic [2:0] {
    U_IDLE, U_JUST, U_SQR, U_SQRT, U_LOAD, U_DIV, U_DONE
  } unit_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tntu_front.sv =====
// ----------------------------------------------------------------------------
// Triangle normal and tangent unit: front end
// Takes vertices, keeps the first two corners and forms the edge and texture
// differences of each triangle for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tntu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tntu_pkg::in_word_t in_word,
  output logic               job_push,
  output tntu_pkg::job_t     job_data,
  input  logic               fifo_full
);

  logic [1:0]         corner_count;
  tntu_pkg::in_word_t p0;
  tntu_pkg::in_word_t p1;
  logic               accept;

  assign in_ready = (corner_count != tntu_pkg::LAST_CORNER) || !fifo_full;
  assign accept   = in_valid && in_ready;
  assign job_push = accept && (corner_count == tntu_pkg::LAST_CORNER);

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= 2'd0;
    end else if (accept) begin
      if (corner_count == tntu_pkg::LAST_CORNER) begin
        corner_count <= 2'd0;
      end else begin
        corner_count <= corner_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && corner_count == 2'd0) begin
      p0 <= in_word;
    end
    if (accept && corner_count == 2'd1) begin
      p1 <= in_word;
    end
  end

  always_comb begin
    job_data.e1_x = tntu_pkg::PD_WIDTH'(p1.pos_x) - tntu_pkg::PD_WIDTH'(p0.pos_x);
    job_data.e1_y = tntu_pkg::PD_WIDTH'(p1.pos_y) - tntu_pkg::PD_WIDTH'(p0.pos_y);
    job_data.e1_z = tntu_pkg::PD_WIDTH'(p1.pos_z) - tntu_pkg::PD_WIDTH'(p0.pos_z);
    job_data.e2_x = tntu_pkg::PD_WIDTH'(in_word.pos_x) - tntu_pkg::PD_WIDTH'(p0.pos_x);
    job_data.e2_y = tntu_pkg::PD_WIDTH'(in_word.pos_y) - tntu_pkg::PD_WIDTH'(p0.pos_y);
    job_data.e2_z = tntu_pkg::PD_WIDTH'(in_word.pos_z) - tntu_pkg::PD_WIDTH'(p0.pos_z);
    job_data.du1  = tntu_pkg::TD_WIDTH'(p1.tex_u) - tntu_pkg::TD_WIDTH'(p0.tex_u);
    job_data.du2  = tntu_pkg::TD_WIDTH'(in_word.tex_u) - tntu_pkg::TD_WIDTH'(p0.tex_u);
    job_data.dv1  = tntu_pkg::TD_WIDTH'(p0.tex_v) - tntu_pkg::TD_WIDTH'(p1.tex_v);
    job_data.dv2  = tntu_pkg::TD_WIDTH'(p0.tex_v) - tntu_pkg::TD_WIDTH'(in_word.tex_v);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tntu_fifo.sv =====
// ----------------------------------------------------------------------------
// Triangle normal and tangent unit: job queue
// Short first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tntu_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tntu_pkg::job_t push_data,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop,
  output tntu_pkg::job_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tntu_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tntu_unitize.sv =====
// ----------------------------------------------------------------------------
// Triangle normal and tangent unit: vector normaliser
// Left-justifies the magnitudes, sums their squares, takes a bit-serial square
// root and divides each component with a restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tntu_unitize (
  input  logic                clk,
  input  logic                rst,
  input  tntu_pkg::unit_req_t req,
  output tntu_pkg::unit_res_t res
);

  localparam int JW  = tntu_pkg::JUS_WIDTH;
  localparam int AW  = tntu_pkg::ACC_WIDTH;
  localparam int SW  = tntu_pkg::SM_WIDTH;
  localparam int OW  = tntu_pkg::OUT_WIDTH;
  localparam int QB  = tntu_pkg::QB_WIDTH;
  localparam int NW  = tntu_pkg::NUM_WIDTH;
  localparam int DW  = tntu_pkg::DIV_WIDTH;
  localparam int RW  = tntu_pkg::REM_WIDTH;
  localparam int RTW = tntu_pkg::ROOT_WIDTH;
  localparam int BW  = tntu_pkg::BC_WIDTH;
  localparam logic [QB-1:0] QMAX = QB'((1 << (OW - 1)) - 1);

  tntu_pkg::unit_state_t state;
  tntu_pkg::unit_state_t state_next;

  logic [JW-1:0]      m [3];
  logic               neg [3];
  logic [OW-1:0]      o [3];
  logic               degen;
  logic [1:0]         cnt;
  logic [1:0]         comp;
  logic [4:0]         sq_step;
  logic [2*SW-1:0]    sq;
  logic [tntu_pkg::SUM_WIDTH-1:0] sum;
  logic [RW-1:0]      srem;
  logic [RTW-1:0]     root;
  logic [NW-1:0]      drem;
  logic [DW-1:0]      dvs;
  logic [QB-1:0]      q;
  logic [BW-1:0]      bitc;

  logic [AW-1:0]      a0, a1, a2;
  logic               in_zero;
  logic               top_any;
  logic [SW-1:0]      sm0;
  logic [RW-1:0]      rem2;
  logic [RW-1:0]      trial;
  logic               sq_ge;
  logic               div_ge;
  logic [QB-1:0]      q_fin;
  logic [QB-1:0]      q_sat;
  logic [OW-1:0]      q_out;

  function automatic logic [AW-1:0] mag_of(input logic signed [AW-1:0] v);
    return v[AW-1] ? (~v + AW'(1)) : v;
  endfunction

  assign a0      = mag_of(req.v0);
  assign a1      = mag_of(req.v1);
  assign a2      = mag_of(req.v2);
  assign in_zero = (req.v0 == '0) && (req.v1 == '0) && (req.v2 == '0);
  assign top_any = m[0][JW-1] | m[1][JW-1] | m[2][JW-1];
  assign sm0     = m[0][JW-1 -: SW];
  assign rem2    = {srem[RW-3:0], sum[tntu_pkg::SUM_WIDTH-1 -: 2]};
  assign trial   = RW'({root, 2'b01});
  assign sq_ge   = (rem2 >= trial);
  assign div_ge  = (DW'(drem) >= dvs);
  assign q_fin   = {q[QB-2:0], div_ge};
  assign q_sat   = (q_fin > QMAX) ? QMAX : q_fin;
  assign q_out   = neg[0] ? (~q_sat[OW-1:0] + OW'(1)) : q_sat[OW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      tntu_pkg::U_IDLE: begin
        if (req.start) begin
          state_next = in_zero ? tntu_pkg::U_DONE : tntu_pkg::U_JUST;
        end
      end
      tntu_pkg::U_JUST: begin
        if (top_any) begin
          state_next = tntu_pkg::U_SQR;
        end
      end
      tntu_pkg::U_SQR: begin
        if (cnt == 2'd3) begin
          state_next = tntu_pkg::U_SQRT;
        end
      end
      tntu_pkg::U_SQRT: begin
        if (sq_step == 5'd31) begin
          state_next = tntu_pkg::U_LOAD;
        end
      end
      tntu_pkg::U_LOAD: begin
        state_next = tntu_pkg::U_DIV;
      end
      tntu_pkg::U_DIV: begin
        if (bitc == BW'(QB - 1)) begin
          state_next = (comp == 2'd2) ? tntu_pkg::U_DONE : tntu_pkg::U_LOAD;
        end
      end
      tntu_pkg::U_DONE: begin
        state_next = tntu_pkg::U_IDLE;
      end
      default: begin
        state_next = tntu_pkg::U_IDLE;
      end
    endcase
  end

  always_comb begin
    res.done  = (state == tntu_pkg::U_DONE);
    res.degen = degen;
    res.c0    = o[0];
    res.c1    = o[1];
    res.c2    = o[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tntu_pkg::U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tntu_pkg::U_IDLE: begin
        if (req.start) begin
          m[0]   <= JW'(a0);
          m[1]   <= JW'(a1);
          m[2]   <= JW'(a2);
          neg[0] <= req.v0[AW-1] ^ req.flip;
          neg[1] <= req.v1[AW-1] ^ req.flip;
          neg[2] <= req.v2[AW-1] ^ req.flip;
          degen  <= in_zero;
          comp   <= 2'd0;
          if (in_zero) begin
            o[0] <= '0;
            o[1] <= '0;
            o[2] <= '0;
          end
        end
      end
      tntu_pkg::U_JUST: begin
        cnt <= 2'd0;
        sum <= '0;
        if (!top_any) begin
          m[0] <= m[0] << 1;
          m[1] <= m[1] << 1;
          m[2] <= m[2] << 1;
        end
      end
      tntu_pkg::U_SQR: begin
        cnt <= cnt + 2'd1;
        if (cnt != 2'd3) begin
          sq     <= sm0 * sm0;
          m[0]   <= m[1];
          m[1]   <= m[2];
          m[2]   <= m[0];
          neg[0] <= neg[1];
          neg[1] <= neg[2];
          neg[2] <= neg[0];
        end
        if (cnt != 2'd0) begin
          sum <= sum + tntu_pkg::SUM_WIDTH'(sq);
        end
        srem    <= '0;
        root    <= '0;
        sq_step <= 5'd0;
      end
      tntu_pkg::U_SQRT: begin
        sq_step <= sq_step + 5'd1;
        sum     <= sum << 2;
        if (sq_ge) begin
          srem <= rem2 - trial;
          root <= {root[RTW-2:0], 1'b1};
        end else begin
          srem <= rem2;
          root <= {root[RTW-2:0], 1'b0};
        end
      end
      tntu_pkg::U_LOAD: begin
        drem <= NW'({sm0, {(OW - 1){1'b0}}}) + NW'(root >> 1);
        dvs  <= DW'(root) << (QB - 1);
        q    <= '0;
        bitc <= '0;
      end
      tntu_pkg::U_DIV: begin
        bitc <= bitc + BW'(1);
        q    <= q_fin;
        dvs  <= dvs >> 1;
        if (div_ge) begin
          drem <= drem - NW'(dvs);
        end
        if (bitc == BW'(QB - 1)) begin
          o[0]   <= o[1];
          o[1]   <= o[2];
          o[2]   <= q_out;
          m[0]   <= m[1];
          m[1]   <= m[2];
          m[2]   <= m[0];
          neg[0] <= neg[1];
          neg[1] <= neg[2];
          neg[2] <= neg[0];
          comp   <= comp + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tntu_back.sv =====
// ----------------------------------------------------------------------------
// Triangle normal and tangent unit: back end
// Forms cross product, UV determinant and tangent with one shared multiplier;
// normalises the normal, and the tangent if det != 0; holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tntu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_pop,
  input  tntu_pkg::job_t      job,
  output logic                out_valid,
  input  logic                out_ready,
  output tntu_pkg::out_word_t out_word
);

  localparam int MW = tntu_pkg::MUL_WIDTH;
  localparam int AW = tntu_pkg::ACC_WIDTH;

  tntu_pkg::back_state_t state;
  tntu_pkg::back_state_t state_next;

  tntu_pkg::job_t          job_q;
  logic [3:0]              step;
  logic signed [MW-1:0]    op_a;
  logic signed [MW-1:0]    op_b;
  logic signed [2*MW-1:0]  prod;
  logic [3:0]              prod_idx;
  logic                    prod_vld;
  logic signed [AW-1:0]    acc [7];
  logic signed [AW-1:0]    det;
  tntu_pkg::out_word_t     res;
  tntu_pkg::unit_req_t     ureq;
  tntu_pkg::unit_res_t     ures;
  logic                    out_load;

  assign det      = acc[tntu_pkg::DET_SLOT];
  assign out_load = (state == tntu_pkg::B_FINISH) && (!out_valid || out_ready);

  always_comb begin
    case (step)
      4'd0:    begin op_a = MW'(job_q.e1_y); op_b = MW'(job_q.e2_z); end
      4'd1:    begin op_a = MW'(job_q.e1_z); op_b = MW'(job_q.e2_y); end
      4'd2:    begin op_a = MW'(job_q.e1_z); op_b = MW'(job_q.e2_x); end
      4'd3:    begin op_a = MW'(job_q.e1_x); op_b = MW'(job_q.e2_z); end
      4'd4:    begin op_a = MW'(job_q.e1_x); op_b = MW'(job_q.e2_y); end
      4'd5:    begin op_a = MW'(job_q.e1_y); op_b = MW'(job_q.e2_x); end
      4'd6:    begin op_a = MW'(job_q.du1);  op_b = MW'(job_q.dv2);  end
      4'd7:    begin op_a = MW'(job_q.du2);  op_b = MW'(job_q.dv1);  end
      4'd8:    begin op_a = MW'(job_q.dv2);  op_b = MW'(job_q.e1_x); end
      4'd9:    begin op_a = MW'(job_q.dv1);  op_b = MW'(job_q.e2_x); end
      4'd10:   begin op_a = MW'(job_q.dv2);  op_b = MW'(job_q.e1_y); end
      4'd11:   begin op_a = MW'(job_q.dv1);  op_b = MW'(job_q.e2_y); end
      4'd12:   begin op_a = MW'(job_q.dv2);  op_b = MW'(job_q.e1_z); end
      4'd13:   begin op_a = MW'(job_q.dv1);  op_b = MW'(job_q.e2_z); end
      default: begin op_a = '0;              op_b = '0;              end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      tntu_pkg::B_IDLE: begin
        if (job_valid) begin
          state_next = tntu_pkg::B_MUL;
        end
      end
      tntu_pkg::B_MUL: begin
        if (step == tntu_pkg::NUM_PROD) begin
          state_next = tntu_pkg::B_NSTART;
        end
      end
      tntu_pkg::B_NSTART: begin
        state_next = tntu_pkg::B_NWAIT;
      end
      tntu_pkg::B_NWAIT: begin
        if (ures.done) begin
          state_next = tntu_pkg::B_TSTART;
        end
      end
      tntu_pkg::B_TSTART: begin
        state_next = (det == '0) ? tntu_pkg::B_FINISH : tntu_pkg::B_TWAIT;
      end
      tntu_pkg::B_TWAIT: begin
        if (ures.done) begin
          state_next = tntu_pkg::B_FINISH;
        end
      end
      tntu_pkg::B_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = tntu_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = tntu_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    job_pop    = (state == tntu_pkg::B_IDLE) && job_valid;
    ureq.start = (state == tntu_pkg::B_NSTART)
              || ((state == tntu_pkg::B_TSTART) && (det != '0));
    ureq.flip  = (state == tntu_pkg::B_TSTART) && det[AW-1];
    if (state == tntu_pkg::B_NSTART) begin
      ureq.v0 = acc[0];
      ureq.v1 = acc[1];
      ureq.v2 = acc[2];
    end else begin
      ureq.v0 = acc[4];
      ureq.v1 = acc[5];
      ureq.v2 = acc[6];
    end
  end

  tntu_unitize u_unitize (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .res (ures)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tntu_pkg::B_IDLE;
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      prod_vld <= (state == tntu_pkg::B_MUL) && (step < tntu_pkg::NUM_PROD);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_q <= job;
    end
    if (state == tntu_pkg::B_MUL) begin
      step <= step + 4'd1;
    end else begin
      step <= 4'd0;
    end
    if (state == tntu_pkg::B_MUL && step < tntu_pkg::NUM_PROD) begin
      prod     <= op_a * op_b;
      prod_idx <= step;
    end
    if (prod_vld) begin
      if (!prod_idx[0]) begin
        acc[prod_idx[3:1]] <= AW'(prod);
      end else begin
        acc[prod_idx[3:1]] <= acc[prod_idx[3:1]] - AW'(prod);
      end
    end
    if (state == tntu_pkg::B_NWAIT && ures.done) begin
      res.normal_x          <= ures.c0;
      res.normal_y          <= ures.c1;
      res.normal_z          <= ures.c2;
      res.normal_degenerate <= ures.degen;
    end
    if (state == tntu_pkg::B_TSTART && det == '0) begin
      res.tangent_x          <= '0;
      res.tangent_y          <= '0;
      res.tangent_z          <= '0;
      res.tangent_degenerate <= 1'b1;
    end
    if (state == tntu_pkg::B_TWAIT && ures.done) begin
      res.tangent_x          <= ures.c0;
      res.tangent_y          <= ures.c1;
      res.tangent_z          <= ures.c2;
      res.tangent_degenerate <= ures.degen;
    end
    if (out_load) begin
      out_word <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_normal_tangent_unit.sv =====
// ----------------------------------------------------------------------------
// Triangle normal and tangent unit
// Vertices are taken one a cycle; every third vertex closes a triangle and
// queues one job, and waits to be taken while the job queue is full.
// The back end forms its products with the shared multiplier, then makes
// two passes through the normaliser, each with left-justify shifts, a
// 32-step square root and a bit-serial divider per component. A zero vector
// skips the normaliser's steps, and a zero determinant skips the tangent pass.
// Once the queue is full, three vertices are taken per back-end triangle time.
// Synchronous reset empties the queue and clears the corner count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_normal_tangent_unit #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tntu_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output tntu_pkg::out_word_t out_word
);

  logic           job_push;
  logic           fifo_full;
  logic           job_valid;
  logic           job_pop;
  tntu_pkg::job_t push_data;
  tntu_pkg::job_t pop_data;

  tntu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .job_push  (job_push),
    .job_data  (push_data),
    .fifo_full (fifo_full)
  );

  tntu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop_valid (job_valid),
    .pop       (job_pop),
    .pop_data  (pop_data)
  );

  tntu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !fifo_full)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_valid)
    else $error("job queue read while empty");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> fifo_full)
    else $error("input stalled without a full queue");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the triangle normal and tangent unit
// Vertex words are sent over a valid/ready channel and every third one closes
// a triangle. An exact integer predictor works out the unit normal, the unit
// tangent and both degenerate flags, and each result word is checked field by
// field against the oldest prediction. Directed corner cases come first, then
// random triangles under phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    tntu_pkg::in_word_t word;
    int                 phase;
    bit                 drain;
  } vertex_job_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tntu_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tntu_pkg::out_word_t out_word;

  vertex_job_t         pending_vertices[$];
  tntu_pkg::out_word_t expected_faces[$];
  int          phase = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          in_taken = 1'b0;
  bit          failed = 1'b0;

  int          corner = 0;
  longint      corner_pos[2][3];
  longint      corner_tex[2][2];

  triangle_normal_tangent_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic void unit_vector(input wide_t a, input wide_t b, input wide_t c,
                                      output logic [tntu_pkg::OUT_WIDTH-1:0] o0,
                                      output logic [tntu_pkg::OUT_WIDTH-1:0] o1,
                                      output logic [tntu_pkg::OUT_WIDTH-1:0] o2,
                                      output logic degen);
    wide_t           v[3];
    logic [127:0]    mag[3];
    logic [127:0]    all_bits;
    longint unsigned sm[3];
    longint unsigned q[3];
    longint unsigned total;
    longint unsigned root;
    longint unsigned scale;
    int              len;
    int              sh;
    v[0] = a;
    v[1] = b;
    v[2] = c;
    scale = 64'd1 << (tntu_pkg::OUT_WIDTH - 1);
    all_bits = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      all_bits |= mag[i];
    end
    if (all_bits == 0) begin
      o0 = '0;
      o1 = '0;
      o2 = '0;
      degen = 1'b1;
      return;
    end
    len = 0;
    for (int i = 127; i >= 0; i--) begin
      if (all_bits[i] && len == 0) len = i + 1;
    end
    sh = len - 30;
    total = 0;
    for (int i = 0; i < 3; i++) begin
      sm[i] = sh >= 0 ? 64'(mag[i] >> sh) : 64'(mag[i] << (-sh));
      total += sm[i] * sm[i];
    end
    root = floor_sqrt(total);
    for (int i = 0; i < 3; i++) begin
      q[i] = (sm[i] * scale + (root >> 1)) / root;
      if (q[i] > scale - 1) q[i] = scale - 1;
      if (v[i] < 0) q[i] = -q[i];
    end
    o0 = q[0][tntu_pkg::OUT_WIDTH-1:0];
    o1 = q[1][tntu_pkg::OUT_WIDTH-1:0];
    o2 = q[2][tntu_pkg::OUT_WIDTH-1:0];
    degen = 1'b0;
  endfunction

  // Takes one vertex; returns 1 with the face word when it closes a triangle.
  function automatic bit face_of_vertex(input tntu_pkg::in_word_t w,
                                        output tntu_pkg::out_word_t face);
    longint p[3];
    longint u;
    longint v;
    longint e1[3];
    longint e2[3];
    longint du1;
    longint du2;
    longint dv1;
    longint dv2;
    wide_t  nrm[3];
    wide_t  tan[3];
    wide_t  det;
    p[0] = w.pos_x;
    p[1] = w.pos_y;
    p[2] = w.pos_z;
    u = w.tex_u;
    v = w.tex_v;
    if (corner < 2) begin
      for (int i = 0; i < 3; i++) corner_pos[corner][i] = p[i];
      corner_tex[corner][0] = u;
      corner_tex[corner][1] = v;
      corner++;
      return 1'b0;
    end
    corner = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = corner_pos[1][i] - corner_pos[0][i];
      e2[i] = p[i] - corner_pos[0][i];
    end
    du1 = corner_tex[1][0] - corner_tex[0][0];
    du2 = u - corner_tex[0][0];
    dv1 = corner_tex[0][1] - corner_tex[1][1];
    dv2 = corner_tex[0][1] - v;
    nrm[0] = wide_t'(e1[1]) * e2[2] - wide_t'(e1[2]) * e2[1];
    nrm[1] = wide_t'(e1[2]) * e2[0] - wide_t'(e1[0]) * e2[2];
    nrm[2] = wide_t'(e1[0]) * e2[1] - wide_t'(e1[1]) * e2[0];
    unit_vector(nrm[0], nrm[1], nrm[2], face.normal_x, face.normal_y, face.normal_z,
                face.normal_degenerate);
    det = wide_t'(du1) * dv2 - wide_t'(du2) * dv1;
    for (int i = 0; i < 3; i++) begin
      tan[i] = wide_t'(dv2) * e1[i] - wide_t'(dv1) * e2[i];
      if (det < 0) tan[i] = -tan[i];
    end
    if (det == 0) begin
      face.tangent_x = '0;
      face.tangent_y = '0;
      face.tangent_z = '0;
      face.tangent_degenerate = 1'b1;
    end else begin
      unit_vector(tan[0], tan[1], tan[2], face.tangent_x, face.tangent_y, face.tangent_z,
                  face.tangent_degenerate);
    end
    return 1'b1;
  endfunction

  function automatic bit chance(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (pending_vertices.size() != 0 &&
            !(pending_vertices[0].drain && expected_faces.size() != 0) &&
            !((pending_vertices[0].phase == 1 || pending_vertices[0].phase == 3) &&
              chance(pending_vertices[0].phase == 1 ? 54 : 33))) begin
          phase = pending_vertices[0].phase;
          in_word <= pending_vertices[0].word;
          in_valid <= 1'b1;
          void'(pending_vertices.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_taken = 1'b0;
      if (phase == 2) out_ready <= !chance(54);
      else if (phase == 3) out_ready <= !chance(33);
      else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tntu_pkg::out_word_t face;
    tntu_pkg::out_word_t want;
    bit                  moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        moved = 1'b1;
        if (face_of_vertex(in_word, face)) expected_faces = {expected_faces, face};
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_faces.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word %p", out_word);
        end else begin
          want = expected_faces.pop_front();
          if (out_word.normal_x !== want.normal_x || out_word.normal_y !== want.normal_y ||
              out_word.normal_z !== want.normal_z || out_word.tangent_x !== want.tangent_x ||
              out_word.tangent_y !== want.tangent_y ||
              out_word.tangent_z !== want.tangent_z ||
              out_word.normal_degenerate !== want.normal_degenerate ||
              out_word.tangent_degenerate !== want.tangent_degenerate) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result word differs: expected %p", want);
              $display("                      actual %p", out_word);
            end
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic add_vertex(input longint x, input longint y, input longint z,
                            input longint u, input longint v, input int ph, input bit drain);
    vertex_job_t j;
    j.word.pos_x = x[tntu_pkg::POS_WIDTH-1:0];
    j.word.pos_y = y[tntu_pkg::POS_WIDTH-1:0];
    j.word.pos_z = z[tntu_pkg::POS_WIDTH-1:0];
    j.word.tex_u = u[tntu_pkg::TEX_WIDTH-1:0];
    j.word.tex_v = v[tntu_pkg::TEX_WIDTH-1:0];
    j.phase = ph;
    j.drain = drain;
    pending_vertices = {pending_vertices, j};
  endtask

  function automatic longint any_pos();
    return longint'($signed(tntu_pkg::POS_WIDTH'($urandom)));
  endfunction

  function automatic longint any_tex();
    return longint'($signed(tntu_pkg::TEX_WIDTH'($urandom)));
  endfunction

  initial begin
    longint pmax;
    longint pmin;
    longint tmax;
    longint tmin;
    longint bx;
    longint by;
    longint bz;
    int     kind;
    pmax = 8388607;
    pmin = -8388608;
    tmax = 524287;
    tmin = -524288;
    // Largest spans of every field, positive determinant.
    add_vertex(pmin, pmin, pmin, tmin, tmax, 0, 0);
    add_vertex(pmax, pmin, pmax, tmax, tmax, 0, 0);
    add_vertex(pmin, pmax, pmax, tmin, tmin, 0, 0);
    // Mirrored texture; with these v differences the determinant is positive.
    add_vertex(0, 0, 0, 0, 0, 0, 0);
    add_vertex(4096, 0, 0, 65536, 0, 0, 0);
    add_vertex(0, 4096, 0, 0, -65536, 0, 0);
    // Identical corners: no normal, non-zero determinant but no tangent.
    add_vertex(pmax, pmax, pmax, 0, 0, 0, 0);
    add_vertex(pmax, pmax, pmax, 1000, 0, 0, 0);
    add_vertex(pmax, pmax, pmax, 0, 1000, 0, 0);
    // Collinear corners with all texture coordinates equal.
    add_vertex(-5, 7, 3, tmax, tmin, 0, 0);
    add_vertex(-3, 9, 5, tmax, tmin, 0, 0);
    add_vertex(1, 13, 9, tmax, tmin, 0, 0);
    // Sheared texture with a zero determinant but a proper normal.
    add_vertex(0, 0, 0, 0, 0, 0, 0);
    add_vertex(100, 0, 0, 300, 300, 0, 0);
    add_vertex(0, 100, 0, -200, -200, 0, 0);
    // Tiny triangle, mixed signs.
    add_vertex(-1, -1, 0, -1, 1, 0, 0);
    add_vertex(0, -1, 1, 1, 0, 0, 0);
    add_vertex(-1, 0, 1, 0, -1, 0, 0);
    // Extreme texture values on an axis-aligned face.
    add_vertex(0, 0, pmax, tmax, tmin, 0, 0);
    add_vertex(pmax, 0, pmax, tmin, tmin, 0, 0);
    add_vertex(0, pmin, pmax, tmax, tmax, 0, 0);
    for (int ph = 0; ph < 4; ph++) begin
      for (int t = 0; t < 42; t++) begin
        kind = $urandom_range(9, 0);
        bx = any_pos();
        by = any_pos();
        bz = any_pos();
        for (int k = 0; k < 3; k++) begin
          if (kind < 5) begin
            add_vertex(any_pos(), any_pos(), any_pos(), any_tex(), any_tex(), ph, t == 0 && k == 0);
          end else if (kind < 8) begin
            add_vertex($signed($urandom_range(8000, 0)) - 4000,
                       $signed($urandom_range(8000, 0)) - 4000,
                       $signed($urandom_range(8000, 0)) - 4000,
                       $signed($urandom_range(200, 0)) - 100,
                       $signed($urandom_range(200, 0)) - 100, ph, t == 0 && k == 0);
          end else if (kind == 8) begin
            add_vertex(bx, by, bz, any_tex(), any_tex(), ph, t == 0 && k == 0);
          end else begin
            add_vertex(any_pos(), any_pos(), any_pos(), 12345, 777, ph, t == 0 && k == 0);
          end
        end
      end
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (pending_vertices.size() != 0 || in_valid || expected_faces.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
    if (!failed && expected_faces.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
